// File: sv/i2cbm_pkg.sv
package i2cbm_pkg;

    // Register map
    localparam int unsigned REG_TICKS_PER_US = 0;
    localparam int unsigned REG_ACK_LIMIT    = 1;

    localparam logic [7:0] TICKS_PER_US_RESET = 8'd50;
    localparam logic [7:0] ACK_LIMIT_RESET    = 8'd250;

    // Delay counter width: five microseconds of at most 255 ticks each
    localparam int unsigned DLY_W = 11;

    // Raw command codes on the kind field
    localparam logic [2:0] KIND_NONE  = 3'd0;
    localparam logic [2:0] KIND_START = 3'd1;
    localparam logic [2:0] KIND_STOP  = 3'd2;
    localparam logic [2:0] KIND_WRITE = 3'd3;
    localparam logic [2:0] KIND_ACK   = 3'd4;
    localparam logic [2:0] KIND_READ  = 3'd5;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_START,
        CMD_STOP,
        CMD_WRITE,
        CMD_ACK,
        CMD_READ
    } cmd_t;

    typedef enum logic [4:0] {
        PH_IDLE,
        PH_ST_A,
        PH_ST_B,
        PH_ST_C,
        PH_ST_D,
        PH_SP_A,
        PH_SP_B,
        PH_SP_C,
        PH_WR_A,
        PH_WR_B,
        PH_WR_C,
        PH_AK_A,
        PH_AK_B,
        PH_AK_POLL,
        PH_RD_A,
        PH_RD_B,
        PH_KA,
        PH_KB
    } phase_t;

    // One classified tick as held in the queue
    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] write_byte;
        logic       send_ack;
        logic       sda_in;
    } tick_t;

    // Configuration seen by the sequencer
    typedef struct packed {
        logic [7:0] ticks_per_us;
        logic [7:0] ack_limit;
    } cfg_t;

    // One result transfer
    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       ready_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_error;
    } res_t;

endpackage

// File: sv/i2cbm_front.sv
module i2cbm_front
    import i2cbm_pkg::*;
(
    input  logic [2:0] kind,
    input  logic [7:0] write_byte,
    input  logic       send_ack,
    input  logic       sda_in,
    output tick_t      tick
);

    // Classify the raw kind code; unused codes become no command
    always_comb
    begin
        case (kind)
            KIND_START: tick.cmd = CMD_START;
            KIND_STOP:  tick.cmd = CMD_STOP;
            KIND_WRITE: tick.cmd = CMD_WRITE;
            KIND_ACK:   tick.cmd = CMD_ACK;
            KIND_READ:  tick.cmd = CMD_READ;
            default:    tick.cmd = CMD_NONE;
        endcase
        tick.write_byte = write_byte;
        tick.send_ack   = send_ack;
        tick.sda_in     = sda_in;
    end

endmodule

// File: sv/i2cbm_queue.sv
module i2cbm_queue
    import i2cbm_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  tick_t push_data,
    input  logic  pop,
    output logic  full,
    output logic  not_empty,
    output tick_t head,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    tick_t              mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign count     = count_reg;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold the entries; no reset on payload
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: sv/i2cbm_back.sv
module i2cbm_back
    import i2cbm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  q_not_empty,
    input  tick_t q_head,
    output logic  q_pop,
    output logic  out_valid,
    input  logic  out_stall,
    output res_t  res
);

    phase_t           phase_reg, phase_next;
    logic [DLY_W-1:0] dly_reg, dly_next;
    logic [3:0]       bit_reg, bit_next;
    logic [7:0]       shift_reg, shift_next;
    logic [7:0]       poll_reg, poll_next;
    logic             ack_reg, ack_next;
    logic             scl_reg, scl_next;
    logic             sda_reg, sda_next;
    logic [7:0]       held_reg, held_next;
    logic             err_reg, err_next;
    logic             done_next;
    logic             valid_reg;
    res_t             res_reg;

    logic [7:0]       tick_us;
    logic [DLY_W-1:0] d1, d2, d5;
    phase_t           target;
    logic             do_enter;

    // Segment lengths of one, two and five microseconds
    assign tick_us = (cfg.ticks_per_us == 8'd0) ? 8'd1 : cfg.ticks_per_us;
    assign d1      = {3'b000, tick_us};
    assign d2      = {2'b00, tick_us, 1'b0};
    assign d5      = {3'b000, tick_us} + {1'b0, tick_us, 2'b00};

    // Take the next tick whenever the output register is free or drains
    assign q_pop     = q_not_empty && (!valid_reg || !out_stall);
    assign out_valid = valid_reg;
    assign res       = res_reg;

    // One bus tick: idle decode, ack polling or segment countdown, then entry
    always_comb
    begin
        phase_next = phase_reg;
        dly_next   = dly_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        poll_next  = poll_reg;
        ack_next   = ack_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        held_next  = held_reg;
        err_next   = err_reg;
        done_next  = 1'b0;
        target     = PH_IDLE;
        do_enter   = 1'b0;

        if (phase_reg == PH_IDLE)
        begin
            bit_next = 4'd0;
            case (q_head.cmd)
                CMD_START:
                begin
                    target   = PH_ST_A;
                    do_enter = 1'b1;
                end
                CMD_STOP:
                begin
                    target   = PH_SP_A;
                    do_enter = 1'b1;
                end
                CMD_WRITE:
                begin
                    shift_next = q_head.write_byte;
                    target     = PH_WR_A;
                    do_enter   = 1'b1;
                end
                CMD_ACK:
                begin
                    err_next = 1'b0;
                    target   = PH_AK_A;
                    do_enter = 1'b1;
                end
                CMD_READ:
                begin
                    shift_next = 8'd0;
                    ack_next   = q_head.send_ack;
                    target     = PH_RD_A;
                    do_enter   = 1'b1;
                end
                default:
                begin
                    do_enter = 1'b0;
                end
            endcase
        end
        else if (phase_reg == PH_AK_POLL)
        begin
            if (!q_head.sda_in)
            begin
                scl_next   = 1'b0;
                phase_next = PH_IDLE;
                done_next  = 1'b1;
            end
            else if (poll_reg >= cfg.ack_limit)
            begin
                err_next = 1'b1;
                target   = PH_SP_A;
                do_enter = 1'b1;
            end
            else
            begin
                poll_next = poll_reg + 8'd1;
            end
        end
        else
        begin
            if (dly_reg != '0)
            begin
                dly_next = dly_reg - 1'b1;
            end
            if (dly_next == '0)
            begin
                case (phase_reg)
                    PH_ST_A:
                    begin
                        target   = PH_ST_B;
                        do_enter = 1'b1;
                    end
                    PH_ST_B:
                    begin
                        target   = PH_ST_C;
                        do_enter = 1'b1;
                    end
                    PH_ST_C:
                    begin
                        target   = PH_ST_D;
                        do_enter = 1'b1;
                    end
                    PH_SP_A:
                    begin
                        target   = PH_SP_B;
                        do_enter = 1'b1;
                    end
                    PH_SP_B:
                    begin
                        target   = PH_SP_C;
                        do_enter = 1'b1;
                    end
                    PH_WR_A:
                    begin
                        target   = PH_WR_B;
                        do_enter = 1'b1;
                    end
                    PH_WR_B:
                    begin
                        target   = PH_WR_C;
                        do_enter = 1'b1;
                    end
                    PH_WR_C:
                    begin
                        bit_next   = bit_reg + 4'd1;
                        shift_next = {shift_reg[6:0], 1'b0};
                        if (!bit_next[3])
                        begin
                            target   = PH_WR_A;
                            do_enter = 1'b1;
                        end
                    end
                    PH_AK_A:
                    begin
                        target   = PH_AK_B;
                        do_enter = 1'b1;
                    end
                    PH_AK_B:
                    begin
                        target   = PH_AK_POLL;
                        do_enter = 1'b1;
                    end
                    PH_RD_A:
                    begin
                        target   = PH_RD_B;
                        do_enter = 1'b1;
                    end
                    PH_RD_B:
                    begin
                        bit_next = bit_reg + 4'd1;
                        if (bit_next[3])
                        begin
                            held_next = shift_reg;
                            target    = PH_KA;
                        end
                        else
                        begin
                            target = PH_RD_A;
                        end
                        do_enter = 1'b1;
                    end
                    PH_KA:
                    begin
                        target   = PH_KB;
                        do_enter = 1'b1;
                    end
                    PH_KB:
                    begin
                        scl_next = 1'b0;
                    end
                    default:
                    begin
                        do_enter = 1'b0;
                    end
                endcase
                // Finish the command when no further segment follows
                if (!do_enter)
                begin
                    phase_next = PH_IDLE;
                    dly_next   = '0;
                    done_next  = 1'b1;
                end
            end
        end

        // Enter the chosen segment: drive levels and load its delay
        if (do_enter)
        begin
            phase_next = target;
            case (target)
                PH_ST_A:
                begin
                    sda_next = 1'b1;
                    dly_next = d1;
                end
                PH_ST_B:
                begin
                    scl_next = 1'b1;
                    dly_next = d5;
                end
                PH_ST_C:
                begin
                    sda_next = 1'b0;
                    dly_next = d5;
                end
                PH_ST_D:
                begin
                    scl_next = 1'b0;
                    dly_next = d5;
                end
                PH_SP_A:
                begin
                    scl_next = 1'b1;
                    sda_next = 1'b0;
                    dly_next = d1;
                end
                PH_SP_B:
                begin
                    sda_next = 1'b1;
                    dly_next = d5;
                end
                PH_SP_C:
                begin
                    scl_next = 1'b0;
                    dly_next = d5;
                end
                PH_WR_A:
                begin
                    scl_next = 1'b0;
                    sda_next = shift_next[7];
                    dly_next = d5;
                end
                PH_WR_B:
                begin
                    scl_next = 1'b1;
                    dly_next = d5;
                end
                PH_WR_C:
                begin
                    scl_next = 1'b0;
                    dly_next = d5;
                end
                PH_AK_A:
                begin
                    sda_next = 1'b1;
                    dly_next = d1;
                end
                PH_AK_B:
                begin
                    scl_next = 1'b1;
                    dly_next = d1;
                end
                PH_AK_POLL:
                begin
                    poll_next = 8'd0;
                    dly_next  = '0;
                end
                PH_RD_A:
                begin
                    scl_next = 1'b0;
                    sda_next = 1'b1;
                    dly_next = d2;
                end
                PH_RD_B:
                begin
                    scl_next   = 1'b1;
                    shift_next = {shift_next[6:0], q_head.sda_in};
                    dly_next   = d1;
                end
                PH_KA:
                begin
                    scl_next = 1'b0;
                    sda_next = !ack_next;
                    dly_next = d2;
                end
                PH_KB:
                begin
                    scl_next = 1'b1;
                    dly_next = d2;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    dly_next   = '0;
                end
            endcase
        end
    end

    // Update the sequencer state on each popped tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            dly_reg   <= '0;
            bit_reg   <= 4'd0;
            shift_reg <= 8'd0;
            poll_reg  <= 8'd0;
            ack_reg   <= 1'b0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            held_reg  <= 8'd0;
            err_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                phase_reg <= phase_next;
                dly_reg   <= dly_next;
                bit_reg   <= bit_next;
                shift_reg <= shift_next;
                poll_reg  <= poll_next;
                ack_reg   <= ack_next;
                scl_reg   <= scl_next;
                sda_reg   <= sda_next;
                held_reg  <= held_next;
                err_reg   <= err_next;
                valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Load the result register alongside the state
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            res_reg.scl       <= scl_next;
            res_reg.sda_out   <= sda_next;
            res_reg.ready_res <= (phase_next == PH_IDLE);
            res_reg.done_res  <= done_next;
            res_reg.read_data <= held_next;
            res_reg.ack_error <= err_next;
        end
    end

endmodule

// File: sv/i2c_bit_level_master_unit.sv
// Tick-level I2C master sequencer. Every input transfer is one bus tick and
// yields exactly one result transfer carrying the SCL/SDA levels, the idle
// and done flags, the last read byte and the ack timeout flag. A tick may
// carry a start, stop, byte write, ack wait or byte read; a command that
// arrives while one is still running is ignored. Ticks are classified on
// entry and held in a short queue (QUEUE_DEPTH entries); the sequencer takes
// one tick from the queue per clock unless the result output stalls; its
// state update on each popped tick sets that rate. A tick is registered in
// the queue and then in the result register. Segment lengths are 1, 2 and
// 5 microseconds of ticks_per_us ticks (zero reads as one). Registers:
// ticks_per_us at byte address 0 (reset 50), ack_limit at byte address 4
// (reset 250); write them only while idle.
module i2c_bit_level_master_unit
    import i2cbm_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // tick input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  kind,
    input  logic [7:0]  write_byte,
    input  logic        send_ack,
    input  logic        sda_in,
    // result output
    output logic        out_valid,
    input  logic        out_stall,
    output logic        scl,
    output logic        sda_out,
    output logic        ready_res,
    output logic        done_res,
    output logic [7:0]  read_data,
    output logic        ack_error
);

    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [7:0]       tpu_reg;
    logic [7:0]       limit_reg;
    logic             cfg_wr;
    cfg_t             cfg;
    tick_t            front_tick;
    tick_t            q_head;
    logic             q_full;
    logic             q_not_empty;
    logic             q_pop;
    logic [CNT_W-1:0] q_count;
    res_t             res;

    // Register writes and reads; the word index is the address bit above the byte lane
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpu_reg   <= TICKS_PER_US_RESET;
            limit_reg <= ACK_LIMIT_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == 1'(REG_TICKS_PER_US))
            begin
                tpu_reg <= pwdata[7:0];
            end
            if (paddr[2] == 1'(REG_ACK_LIMIT))
            begin
                limit_reg <= pwdata[7:0];
            end
        end
    end

    assign prdata           = (paddr[2] == 1'(REG_ACK_LIMIT)) ? {24'd0, limit_reg}
                                                              : {24'd0, tpu_reg};
    assign cfg.ticks_per_us = tpu_reg;
    assign cfg.ack_limit    = limit_reg;

    // Front: classify incoming ticks
    i2cbm_front u_front (
        .kind       (kind),
        .write_byte (write_byte),
        .send_ack   (send_ack),
        .sda_in     (sda_in),
        .tick       (front_tick)
    );

    assign in_stall = q_full;

    i2cbm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid),
        .push_data (front_tick),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head),
        .count     (q_count)
    );

    // Back: bus sequencer with its result register
    i2cbm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .res         (res)
    );

    assign scl       = res.scl;
    assign sda_out   = res.sda_out;
    assign ready_res = res.ready_res;
    assign done_res  = res.done_res;
    assign read_data = res.read_data;
    assign ack_error = res.ack_error;

`ifndef SYNTHESIS
    // A finishing tick always leaves the sequencer idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> ready_res)
        else $error("done flagged while sequencer busy");

    // A register write lands in the tick-rate register
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr && (paddr[2] == 1'(REG_TICKS_PER_US)) |=> tpu_reg == $past(pwdata[7:0]))
        else $error("ticks_per_us write lost");

    // The queue never holds more than its depth
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= CNT_W'(QUEUE_DEPTH))
        else $error("tick queue overflow");
`endif

endmodule
